// ===== src/mrtu_pkg.sv =====
// Shared types, constants and the CRC-16 byte update for the Modbus RTU frame receiver.
// Used by every module of the block but mrtu_ram; no dependencies of its own.
package mrtu_pkg;

  // Frame store geometry
  localparam int unsigned SLOTS       = 16;
  localparam int unsigned FRAME_BYTES = 256;
  localparam int unsigned SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam int unsigned ADDR_W      = SLOT_W + POS_W;
  localparam int unsigned RAM_DEPTH   = 1 << ADDR_W;

  // Queue depths
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;

  // Frame constants
  localparam logic [8:0]  FRAME_BYTES_L = 9'(FRAME_BYTES);
  localparam logic [7:0]  FC_READ_HOLD    = 8'h03;
  localparam logic [7:0]  FC_WRITE_SINGLE = 8'h06;
  localparam logic [7:0]  FC_WRITE_MULTI  = 8'h10;
  localparam logic [8:0]  SHORT_LEN       = 9'd8;
  localparam logic [8:0]  LONG_BASE       = 9'd9;
  localparam logic [8:0]  COUNT_OFFSET    = 9'd6;
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  ADDR_RESET      = 8'h01;

  // Item kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Result event codes
  localparam logic [1:0] EV_GOOD    = 2'd0;
  localparam logic [1:0] EV_CRC_BAD = 2'd1;
  localparam logic [1:0] EV_READ    = 2'd2;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [3:0] read_slot;
    logic [7:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic [3:0] slot;
    logic [8:0] frame_length;
    logic [7:0] read_data;
  } out_item_t;

  // Command from the parser to the store side
  typedef struct packed {
    logic              is_read;
    logic              has_res;
    logic              in_range;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    logic [1:0]        event_res;
    logic [3:0]        slot;
    logic [8:0]        frame_length;
  } cmd_t;

  // Modbus CRC-16, reflected, one byte
  function automatic logic [15:0] crc16_add(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== src/mrtu_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module mrtu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mrtu_front.sv =====
// Frame parser: accepts items, tracks the frame, runs the CRC and emits store commands.
// Depends on mrtu_pkg.
module mrtu_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  logic               push_i,
  input  mrtu_pkg::in_item_t in_i,
  input  logic               cmd_full_i,
  output logic               cmd_push_o,
  output mrtu_pkg::cmd_t     cmd_o
);
  import mrtu_pkg::*;

  logic [7:0]        addr_q;
  logic [8:0]        pos_q, pos_d;
  logic [8:0]        exp_q, exp_d;
  logic [SLOT_W-1:0] wslot_q, wslot_d;
  logic [15:0]       crc_q, crc_d;
  logic              long_q, long_d;

  logic              accept;
  logic [15:0]       crc_new;
  logic [8:0]        pos_n;
  logic [8:0]        exp_n;
  logic [8:0]        long_len;
  logic [SLOT_W+3:0] wslot_ext;
  logic [SLOT_W+3:0] rslot_ext;
  logic [ADDR_W-1:0] waddr;

  assign accept    = push_i && !cmd_full_i;
  assign crc_new   = crc16_add(crc_q, in_i.data_byte);
  assign pos_n     = pos_q + 9'd1;
  assign long_len  = LONG_BASE + {1'b0, in_i.data_byte};
  assign wslot_ext = {4'b0000, wslot_q};
  assign rslot_ext = {{SLOT_W{1'b0}}, in_i.read_slot};
  assign waddr     = {wslot_q, pos_q[POS_W-1:0]};

  always_comb begin
    pos_d      = pos_q;
    exp_d      = exp_q;
    wslot_d    = wslot_q;
    crc_d      = crc_q;
    long_d     = long_q;
    exp_n      = exp_q;
    cmd_push_o = 1'b0;
    cmd_o      = '0;
    cmd_o.addr  = waddr;
    cmd_o.wdata = in_i.data_byte;
    cmd_o.slot  = wslot_ext[3:0];

    if (accept) begin
      if (in_i.kind == KIND_READ) begin
        cmd_push_o         = 1'b1;
        cmd_o.is_read      = 1'b1;
        cmd_o.has_res      = 1'b1;
        cmd_o.in_range     = (rslot_ext < (SLOT_W + 4)'(SLOTS)) &&
                             ({1'b0, in_i.read_index} < FRAME_BYTES_L);
        cmd_o.addr         = {rslot_ext[SLOT_W-1:0], in_i.read_index[POS_W-1:0]};
        cmd_o.event_res    = EV_READ;
        cmd_o.slot         = in_i.read_slot;
        cmd_o.frame_length = '0;
      end else if (pos_q == 9'd0) begin
        if (in_i.data_byte == addr_q) begin
          cmd_push_o = 1'b1;
          crc_d      = crc_new;
          pos_d      = 9'd1;
        end
      end else if (pos_q == 9'd1) begin
        unique case (in_i.data_byte) inside
          FC_READ_HOLD, FC_WRITE_SINGLE: begin
            cmd_push_o = 1'b1;
            crc_d      = crc_new;
            pos_d      = 9'd2;
            exp_d      = SHORT_LEN;
            long_d     = 1'b0;
          end
          FC_WRITE_MULTI: begin
            cmd_push_o = 1'b1;
            crc_d      = crc_new;
            pos_d      = 9'd2;
            long_d     = 1'b1;
          end
          default: begin
            pos_d = '0;
            exp_d = '0;
            crc_d = CRC_INIT;
          end
        endcase
      end else begin
        if ((pos_q == COUNT_OFFSET) && long_q) begin
          exp_n = long_len;
        end
        if (((pos_q == COUNT_OFFSET) && long_q && (long_len > FRAME_BYTES_L)) ||
            (pos_q >= FRAME_BYTES_L)) begin
          // drop the frame
          pos_d = '0;
          exp_d = '0;
          crc_d = CRC_INIT;
        end else begin
          cmd_push_o = 1'b1;
          crc_d      = crc_new;
          pos_d      = pos_n;
          exp_d      = exp_n;
          if ((exp_n != 9'd0) && (pos_n >= exp_n)) begin
            cmd_o.has_res      = 1'b1;
            cmd_o.event_res    = (crc_new == 16'h0000) ? EV_GOOD : EV_CRC_BAD;
            cmd_o.frame_length = exp_n;
            if (crc_new == 16'h0000) begin
              wslot_d = (wslot_q == SLOT_W'(SLOTS - 1)) ? '0 : wslot_q + SLOT_W'(1);
            end
            pos_d = '0;
            exp_d = '0;
            crc_d = CRC_INIT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= ADDR_RESET;
      pos_q   <= '0;
      exp_q   <= '0;
      wslot_q <= '0;
      crc_q   <= CRC_INIT;
      long_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        addr_q <= cfg_wdata_i;
      end
      pos_q   <= pos_d;
      exp_q   <= exp_d;
      wslot_q <= wslot_d;
      crc_q   <= crc_d;
      long_q  <= long_d;
    end
  end

endmodule

// ===== src/mrtu_cmd_fifo.sv =====
// Short command queue between the parser and the store side.
// Depends on mrtu_pkg.
module mrtu_cmd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mrtu_pkg::cmd_t cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output mrtu_pkg::cmd_t cmd_o
);
  import mrtu_pkg::*;

  localparam int unsigned PTR_W = $clog2(CMD_DEPTH);

  cmd_t             mem_q [CMD_DEPTH];
  logic [PTR_W-1:0] wptr_q, rptr_q;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PTR_W + 1)'(CMD_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (PTR_W + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (PTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + PTR_W'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== src/mrtu_back.sv =====
// Store side: executes writes and reads on the frame RAM in order and queues results.
// Depends on mrtu_pkg and mrtu_ram.
module mrtu_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cmd_empty_i,
  input  mrtu_pkg::cmd_t      cmd_i,
  output logic                cmd_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output mrtu_pkg::out_item_t out_o
);
  import mrtu_pkg::*;

  localparam int unsigned OPTR_W = $clog2(OUT_DEPTH);

  logic             issue;
  logic [7:0]       rdata;
  logic             s_valid_q;
  cmd_t             s_cmd_q;
  out_item_t        s_res;

  out_item_t         omem_q [OUT_DEPTH];
  logic [OPTR_W-1:0] owptr_q, orptr_q;
  logic [OPTR_W:0]   ocnt_q, ocnt_d;
  logic              opop;

  // issue only while the result queue has room for everything in flight
  assign issue = !cmd_empty_i &&
                 (({1'b0, ocnt_q} + (OPTR_W + 2)'(s_valid_q)) < (OPTR_W + 2)'(OUT_DEPTH));
  assign cmd_pop_o = issue;

  mrtu_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (issue && !cmd_i.is_read),
    .addr_i  (cmd_i.addr),
    .wdata_i (cmd_i.wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    s_res.event_res    = s_cmd_q.event_res;
    s_res.slot         = s_cmd_q.slot;
    s_res.frame_length = s_cmd_q.frame_length;
    s_res.read_data    = (s_cmd_q.is_read && s_cmd_q.in_range) ? rdata : 8'h00;
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s_cmd_q <= cmd_i;
    end
    if (s_valid_q) begin
      omem_q[owptr_q] <= s_res;
    end
  end

  assign empty_o = (ocnt_q == '0);
  assign opop    = pop_i && !empty_o;
  assign out_o   = omem_q[orptr_q];

  always_comb begin
    ocnt_d = ocnt_q;
    if (s_valid_q && !opop) begin
      ocnt_d = ocnt_q + (OPTR_W + 1)'(1);
    end else if (opop && !s_valid_q) begin
      ocnt_d = ocnt_q - (OPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      owptr_q   <= '0;
      orptr_q   <= '0;
      ocnt_q    <= '0;
    end else begin
      s_valid_q <= issue && cmd_i.has_res;
      if (s_valid_q) begin
        owptr_q <= owptr_q + OPTR_W'(1);
      end
      if (opop) begin
        orptr_q <= orptr_q + OPTR_W'(1);
      end
      ocnt_q <= ocnt_d;
    end
  end

endmodule

// ===== src/modbus_rtu_frame_receiver_core.sv =====
// Modbus RTU request frame receiver: top level.
// Depends on mrtu_pkg, mrtu_front, mrtu_cmd_fifo and mrtu_back.
//
// Usage:
//   Input queue: drive in_i and raise push_i; the item transfers on a clock
//   edge with push_i high and full_o low. kind 0 carries one received byte,
//   kind 1 asks for one stored byte of a frame slot.
//   Result queue: while empty_o is low, out_o shows the oldest result; it
//   transfers on an edge with pop_i high. Frame events (good frame, CRC
//   mismatch) and read answers come out in the order of their items.
//   Configuration: cfg_we_i writes cfg_wdata_i as the slave address.
//   Throughput: one item per cycle while full_o is low, set by the combinational CRC
//   byte update in the parser and the one RAM access per cycle on the store side.
//   Path: a result passes the command queue, the registered store stage and the
//   result queue before it shows on out_o.
//   Reset: slave address 1, parser idle, write slot 0, both queues empty.
//   The frame RAM is not cleared; bytes never written read as unknown.
//   Stall: when pop_i stays low the result queue fills, the store side stops
//   taking commands, the command queue fills and full_o rises; nothing is lost.
module modbus_rtu_frame_receiver_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  input  logic                push_i,
  output logic                full_o,
  input  mrtu_pkg::in_item_t  in_i,
  output logic                empty_o,
  input  logic                pop_i,
  output mrtu_pkg::out_item_t out_o
);
  import mrtu_pkg::*;

  logic cmd_push, cmd_full, cmd_pop, cmd_empty;
  cmd_t cmd_in, cmd_head;

  mrtu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push_i),
    .in_i        (in_i),
    .cmd_full_i  (cmd_full),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  mrtu_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .cmd_o   (cmd_head)
  );

  mrtu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_o       (out_o)
  );

  assign full_o = cmd_full;

  a_no_push_when_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> !full_o)
    else $error("command pushed into a full queue");

  a_no_pop_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty)
    else $error("command popped from an empty queue");

  a_read_makes_cmd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o && (in_i.kind == KIND_READ)) |-> (cmd_push && cmd_in.is_read))
    else $error("read transfer produced no read command");

  a_cmd_reaches_fifo : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |=> !cmd_empty)
    else $error("pushed command did not show in the queue");

endmodule

// ===== tb/modbus_rtu_frame_receiver_core_test.sv =====
// Testbench for modbus_rtu_frame_receiver_core: RTU frames, CRC errors, dropped headers, reads.
// A scoreboard class predicts each result from the accepted items; needs only mrtu_pkg and the RTL.
`timescale 1ns / 100ps

import mrtu_pkg::*;

// Modbus CRC-16, one byte taken in bit by bit, LSB first
function automatic logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
  logic [15:0] r;
  logic        fb;
  r = c;
  for (int i = 0; i < 8; i++) begin
    fb = r[0] ^ b[i];
    r  = r >> 1;
    if (fb) r = r ^ CRC_POLY;
  end
  return r;
endfunction

class rtu_scoreboard;
  logic [7:0]  slave_addr;
  int unsigned rx_pos;
  int unsigned rx_len;      // 0 while the frame length is still unknown
  int unsigned ring_slot;
  logic [15:0] rx_crc;
  logic [7:0]  frame_mem [SLOTS][FRAME_BYTES];
  bit          written [SLOTS][FRAME_BYTES];
  int unsigned written_addr [$];
  out_item_t   pending_events [$];
  int unsigned errors;

  function new();
    slave_addr = ADDR_RESET;
    ring_slot  = 0;
    errors     = 0;
    restart();
  endfunction

  function void restart();
    rx_pos = 0;
    rx_len = 0;
    rx_crc = CRC_INIT;
  endfunction

  function void store_byte(int unsigned pos, logic [7:0] b);
    frame_mem[ring_slot][pos] = b;
    if (!written[ring_slot][pos]) begin
      written[ring_slot][pos] = 1'b1;
      written_addr.push_back(ring_slot * FRAME_BYTES + pos);
    end
    rx_crc = crc_step(rx_crc, b);
  endfunction

  // Advance the parser by one accepted item and queue the result it causes
  function void take_item(in_item_t it);
    out_item_t  ev;
    logic [7:0] b;
    b = it.data_byte;
    if (it.kind == KIND_READ) begin
      ev.event_res    = EV_READ;
      ev.slot         = it.read_slot;
      ev.frame_length = 9'd0;
      ev.read_data    = frame_mem[it.read_slot][it.read_index];
      pending_events.push_back(ev);
      return;
    end
    if (rx_pos == 0) begin
      if (b == slave_addr) begin
        store_byte(0, b);
        rx_pos = 1;
      end
      return;
    end
    if (rx_pos == 1) begin
      if (b == FC_READ_HOLD || b == FC_WRITE_SINGLE) begin
        store_byte(1, b);
        rx_pos = 2;
        rx_len = SHORT_LEN;
      end else if (b == FC_WRITE_MULTI) begin
        store_byte(1, b);
        rx_pos = 2;
      end else begin
        restart();
      end
      return;
    end
    if (rx_pos == COUNT_OFFSET && frame_mem[ring_slot][1] == FC_WRITE_MULTI) begin
      if (LONG_BASE + b > FRAME_BYTES) begin
        restart();
        return;
      end
      rx_len = LONG_BASE + b;
    end
    if (rx_pos >= FRAME_BYTES) begin
      restart();
      return;
    end
    store_byte(rx_pos, b);
    rx_pos++;
    if (rx_len != 0 && rx_pos >= rx_len) begin
      ev.event_res    = (rx_crc == 16'h0000) ? EV_GOOD : EV_CRC_BAD;
      ev.slot         = 4'(ring_slot);
      ev.frame_length = 9'(rx_len);
      ev.read_data    = 8'h00;
      pending_events.push_back(ev);
      if (rx_crc == 16'h0000) ring_slot = (ring_slot + 1) % SLOTS;
      restart();
    end
  endfunction

  task report(string what);
    errors++;
    if (errors <= 40) $display("mismatch at %0t: %s", $realtime, what);
  endtask

  task check_event(out_item_t got);
    out_item_t want;
    if (pending_events.size() == 0) begin
      report($sformatf("result with nothing pending: event %0d slot %0d len %0d data %02h",
                       got.event_res, got.slot, got.frame_length, got.read_data));
      return;
    end
    want = pending_events.pop_front();
    if (got.event_res !== want.event_res)
      report($sformatf("event %0d, expected %0d", got.event_res, want.event_res));
    if (got.slot !== want.slot)
      report($sformatf("slot %0d, expected %0d", got.slot, want.slot));
    if (got.frame_length !== want.frame_length)
      report($sformatf("length %0d, expected %0d", got.frame_length, want.frame_length));
    if (got.read_data !== want.read_data)
      report($sformatf("read data %02h, expected %02h", got.read_data, want.read_data));
  endtask
endclass

module modbus_rtu_frame_receiver_core_test;
  localparam int unsigned LATENCY = 3;
  localparam int unsigned IN_W    = $bits(in_item_t);

  logic      clk_i;
  logic      rst_ni;
  logic      cfg_we_i;
  logic [7:0] cfg_wdata_i;
  logic      push_i;
  logic      full_o;
  in_item_t  in_i;
  logic      empty_o;
  logic      pop_i;
  out_item_t out_o;

  rtu_scoreboard sb;
  logic [7:0]    frame_buf [$];
  int unsigned   items_sent;
  int unsigned   in_calm;

  modbus_rtu_frame_receiver_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_i        (in_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_o       (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none
  function automatic int unsigned pick_gap(ref int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      push_i <= 1'b0;
      in_i   <= IN_W'($urandom);
      repeat (gap) @(negedge clk_i);
    end
    push_i <= 1'b1;
    in_i   <= it;
    do @(posedge clk_i); while (full_o !== 1'b0);
    sb.take_item(it);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_byte(logic [7:0] b);
    in_item_t it;
    it           = IN_W'($urandom);
    it.kind      = KIND_BYTE;
    it.data_byte = b;
    send_item(it);
  endtask

  task automatic send_read(logic [3:0] s, logic [7:0] idx);
    in_item_t it;
    it            = IN_W'($urandom);
    it.kind       = KIND_READ;
    it.read_slot  = s;
    it.read_index = idx;
    send_item(it);
  endtask

  // Read back only bytes that some frame has already written
  task automatic send_any_read();
    int unsigned a;
    if (sb.written_addr.size() == 0) return;
    a = sb.written_addr[$urandom_range(0, sb.written_addr.size() - 1)];
    send_read(4'(a / FRAME_BYTES), 8'(a % FRAME_BYTES));
  endtask

  function automatic void fill_frame(logic [7:0] code, int unsigned count, bit corrupt);
    logic [15:0] c;
    int unsigned flip;
    frame_buf.delete();
    frame_buf.push_back(sb.slave_addr);
    frame_buf.push_back(code);
    repeat (4) frame_buf.push_back(8'($urandom));
    if (code == FC_WRITE_MULTI) begin
      frame_buf.push_back(8'(count));
      repeat (count) frame_buf.push_back(8'($urandom));
    end
    c = CRC_INIT;
    foreach (frame_buf[i]) c = crc_step(c, frame_buf[i]);
    frame_buf.push_back(c[7:0]);
    frame_buf.push_back(c[15:8]);
    if (corrupt) begin
      // keep the byte count intact so the frame length holds
      flip = $urandom_range(2, frame_buf.size() - 1);
      if (code == FC_WRITE_MULTI && flip == COUNT_OFFSET) flip = frame_buf.size() - 1;
      frame_buf[flip] ^= 8'(1 << $urandom_range(0, 7));
    end
  endfunction

  task automatic send_frame(int unsigned read_pct);
    foreach (frame_buf[i]) begin
      if ($urandom_range(0, 99) < read_pct) send_any_read();
      send_byte(frame_buf[i]);
    end
  endtask

  // Hold the sender until every pending result has come out and the pipe is empty
  task automatic drain();
    push_i <= 1'b0;
    while (sb.pending_events.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_address(logic [7:0] a);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= a;
    sb.slave_addr = a;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_random(int unsigned n_items, bit big_first);
    int unsigned stop_at;
    int unsigned r;
    int unsigned k;
    int unsigned count;
    logic [7:0]  code;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 72) begin
        k    = $urandom_range(0, 9);
        code = (k < 3) ? FC_READ_HOLD : (k < 6) ? FC_WRITE_SINGLE : FC_WRITE_MULTI;
        if (big_first) begin
          code      = FC_WRITE_MULTI;
          count     = FRAME_BYTES - LONG_BASE;
          big_first = 1'b0;
        end else if ($urandom_range(0, 99) < 3) begin
          count = $urandom_range(120, FRAME_BYTES - LONG_BASE);
        end else begin
          count = $urandom_range(0, 24);
        end
        fill_frame(code, count, $urandom_range(0, 99) < 15);
        // cut a few frames short; the parser swallows what follows
        if ($urandom_range(0, 99) < 5) begin
          k = $urandom_range(1, frame_buf.size() - 2);
          frame_buf = frame_buf[0:k];
        end
        send_frame(10);
      end else if (r < 82) begin
        repeat ($urandom_range(1, 6))
          send_byte(($urandom_range(0, 2) == 0) ? sb.slave_addr : 8'($urandom));
      end else if (r < 94) begin
        repeat ($urandom_range(1, 4)) send_any_read();
      end else if (r < 98) begin
        if ($urandom_range(0, 1) == 1) begin
          do code = 8'($urandom);
          while (code == FC_READ_HOLD || code == FC_WRITE_SINGLE || code == FC_WRITE_MULTI);
          send_byte(sb.slave_addr);
          send_byte(code);
        end else begin
          fill_frame(FC_WRITE_MULTI, $urandom_range(FRAME_BYTES - LONG_BASE + 1, 255), 1'b0);
          frame_buf = frame_buf[0:COUNT_OFFSET];
          send_frame(0);
        end
      end else begin
        drain();
      end
    end
  endtask

  // Result side: random pop stalls, check on every transfer
  initial begin
    int unsigned hold;
    int unsigned pop_calm;
    hold     = 0;
    pop_calm = 0;
    pop_i    = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        pop_i <= 1'b0;
        hold--;
      end else begin
        pop_i <= 1'b1;
        hold = pick_gap(pop_calm);
      end
      @(posedge clk_i);
      if (pop_i && empty_o === 1'b0) sb.check_event(out_o);
    end
  end

  initial begin
    sb          = new();
    items_sent  = 0;
    in_calm     = 0;
    rst_ni      = 1'b0;
    push_i      = 1'b0;
    in_i        = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // bytes that do not open a frame, then an unknown function code
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(sb.slave_addr);
    send_byte(8'h42);
    // single write frame; offset 1 holds the code once, offset 2 the first data byte
    fill_frame(FC_WRITE_SINGLE, 0, 1'b0);
    send_frame(0);
    send_read(4'd0, 8'd1);
    send_read(4'd0, 8'd2);
    // read frame with a broken CRC
    fill_frame(FC_READ_HOLD, 0, 1'b1);
    send_frame(0);
    // byte count one past the frame size: drop the header
    fill_frame(FC_WRITE_MULTI, FRAME_BYTES - LONG_BASE + 1, 1'b0);
    frame_buf = frame_buf[0:COUNT_OFFSET];
    send_frame(0);

    run_random(300, 1'b1);
    set_address(8'h00);
    run_random(350, 1'b0);
    set_address(8'hFF);
    run_random(350, 1'b0);
    set_address(8'($urandom));
    run_random(350, 1'b0);
    set_address(FC_READ_HOLD);
    run_random(300, 1'b0);
    drain();

    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end
endmodule
